>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the sphere vertex generator.
// Each macro samples on i_clk and stays quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge out of reset.
`define UVS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check that a condition in the next cycle follows from a condition now.
`define UVS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/uvs_pkg.sv
// Package of the UV-sphere vertex generator: item types, fixed-point constants
// and small helper functions. No dependencies.
`timescale 1ns / 1ps

package uvs_pkg;

    // Field and register widths
    localparam int STEP_W          = 11;
    localparam int SEG_REG_W       = 11;
    localparam int IDX_W           = 21;
    localparam int TEX_W           = 17;
    localparam int POS_W           = 16;
    localparam int CFG_IDX_W       = 2;

    localparam int MAX_SEGMENTS_DEF = 1024;
    localparam int SEG_W_DEF        = $clog2(MAX_SEGMENTS_DEF + 1);

    // Register reset values and indexes
    localparam logic [SEG_REG_W-1:0] LON_RESET = 11'd64;
    localparam logic [SEG_REG_W-1:0] LAT_RESET = 11'd32;
    localparam logic [CFG_IDX_W-1:0] CFG_LON   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAT   = 2'd1;

    // Angle divider: fraction bits of the quarter-turn counts
    localparam int THETA_FRAC = 31;
    localparam int PHI_FRAC   = 32;
    localparam int TEX_FRAC   = 16;
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (PHI_FRAC + DIV_STEPS - 1) / DIV_STEPS;

    // Quarter-wave sine pipeline
    localparam int HORNER_N = 4;
    localparam int SIN_LAT  = 3 + 3 * HORNER_N + 2;
    localparam logic [30:0] ONE30   = 31'h4000_0000;
    localparam logic [30:0] PIH_Q30 = 31'd1686629713;
    localparam logic [63:0] RND30   = 64'h0000_0000_2000_0000;

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    typedef struct packed {
        logic [STEP_W-1:0] lat_step;
        logic [STEP_W-1:0] lon_step;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [TEX_W-1:0]        tex_u;
        logic [TEX_W-1:0]        tex_v;
        logic                    has_quad;
        logic [IDX_W-1:0]        tri0_a;
        logic [IDX_W-1:0]        tri0_b;
        logic [IDX_W-1:0]        tri0_c;
        logic [IDX_W-1:0]        tri1_a;
        logic [IDX_W-1:0]        tri1_b;
        logic [IDX_W-1:0]        tri1_c;
    } t_out_item;

    // Index data computed at the input
    typedef struct packed {
        logic             has_quad;
        logic [IDX_W-1:0] first;
    } t_idx;

    // Data riding alongside the sine pipeline
    typedef struct packed {
        t_quad            qt;
        t_quad            qp;
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
        t_idx             idx;
    } t_side;

    // Carried operands of the Horner steps
    typedef struct packed {
        logic [30:0] x;
        logic [31:0] x2;
    } t_sin_carry;

    // Sine and cosine as sign and magnitude
    typedef struct packed {
        logic        sn_neg;
        logic [30:0] sn_mag;
        logic        cs_neg;
        logic [30:0] cs_mag;
    } t_sc;

    // Product stage ahead of the output register
    typedef struct packed {
        logic [61:0] mx;
        logic        x_neg;
        logic [61:0] mz;
        logic        z_neg;
        logic [15:0] ymag;
        logic        y_neg;
        t_side       side;
    } t_c1;

    // Horner divisors, rounding offsets and floor(2^33 / divisor)
    function automatic logic [6:0] horner_k(input int h);
        case (h)
            0:       return 7'd72;
            1:       return 7'd42;
            2:       return 7'd20;
            default: return 7'd6;
        endcase
    endfunction

    function automatic logic [5:0] horner_c(input int h);
        case (h)
            0:       return 6'd36;
            1:       return 6'd21;
            2:       return 6'd10;
            default: return 6'd3;
        endcase
    endfunction

    function automatic logic [30:0] horner_m(input int h);
        case (h)
            0:       return 31'd119304647;
            1:       return 31'd204522252;
            2:       return 31'd429496729;
            default: return 31'd1431655765;
        endcase
    endfunction

    // Place the quarter-wave values by quadrant
    function automatic t_sc sc_fold(input t_quad q, input logic [30:0] sv,
                                    input logic [30:0] cv);
        t_sc r;
        case (q)
            QUAD_0: r = '{sn_neg: 1'b0, sn_mag: sv, cs_neg: 1'b0, cs_mag: cv};
            QUAD_1: r = '{sn_neg: 1'b0, sn_mag: cv, cs_neg: 1'b1, cs_mag: sv};
            QUAD_2: r = '{sn_neg: 1'b1, sn_mag: sv, cs_neg: 1'b1, cs_mag: cv};
            QUAD_3: r = '{sn_neg: 1'b1, sn_mag: cv, cs_neg: 1'b0, cs_mag: sv};
            default: r = '{sn_neg: 1'b0, sn_mag: sv, cs_neg: 1'b0, cs_mag: cv};
        endcase
        return r;
    endfunction

    // Sign-magnitude to Q1.15 with saturation at both ends
    function automatic logic [15:0] pack_q15(input logic neg, input logic [15:0] mag);
        logic [15:0] sat;
        sat = (mag > 16'd32768) ? 16'd32768 : mag;
        if (neg && mag != 16'd0) begin
            return 16'(17'h10000 - {1'b0, sat});
        end
        return (mag > 16'd32767) ? 16'd32767 : mag;
    endfunction

endpackage

>>> rtl/uvs_dly.sv
// Enabled shift line that carries side data alongside a pipeline.
// Depends on uvs_pkg for the default depth.
`timescale 1ns / 1ps

module uvs_dly
    import uvs_pkg::*;
#(
    parameter int W     = 1,
    parameter int DEPTH = DIV_STAGES
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [DEPTH];

    // Advance every tap together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

>>> rtl/uvs_div.sv
// Pipelined restoring divider for num/den with num <= den, giving one integer
// bit and FRAC_BITS fraction bits plus round-half-up flags. Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_div
    import uvs_pkg::*;
#(
    parameter int SEG_W     = SEG_W_DEF,
    parameter int FRAC_BITS = PHI_FRAC
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SEG_W-1:0]   i_num,
    input  logic [SEG_W-1:0]   i_den,
    output logic [FRAC_BITS:0] o_quo,
    output logic               o_rnd_tex,
    output logic               o_rnd_fin
);

    localparam int QW = FRAC_BITS + 1;

    logic [SEG_W-1:0] r_rem [DIV_STAGES];
    logic [QW-1:0]    r_quo [DIV_STAGES];
    logic             r_rt  [DIV_STAGES];

    logic [SEG_W-1:0] w_half;
    logic             w_ge;
    logic [SEG_W-1:0] w_rem0;

    // Rounding threshold ceil(den/2) and the integer bit
    assign w_half = SEG_W'(({1'b0, i_den} + 1'b1) >> 1);
    assign w_ge   = (i_num >= i_den);
    assign w_rem0 = w_ge ? (i_num - i_den) : i_num;

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        logic [SEG_W-1:0] w_rem_in;
        logic [QW-1:0]    w_quo_in;
        logic             w_rt_in;
        logic [SEG_W-1:0] n_rem;
        logic [QW-1:0]    n_quo;
        logic             n_rt;

        if (s == 0) begin : g_first
            assign w_rem_in = w_rem0;
            assign w_quo_in = QW'(w_ge);
            assign w_rt_in  = 1'b0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_quo_in = r_quo[s-1];
            assign w_rt_in  = r_rt[s-1];
        end

        // Shift, compare and subtract for each quotient bit of this stage
        always_comb begin
            logic [SEG_W:0] v_rem2;
            v_rem2 = '0;
            n_rem  = w_rem_in;
            n_quo  = w_quo_in;
            n_rt   = w_rt_in;
            for (int b = 0; b < DIV_STEPS; b++) begin
                if (s * DIV_STEPS + b + 1 <= FRAC_BITS) begin
                    v_rem2 = {n_rem, 1'b0};
                    if (v_rem2 >= {1'b0, i_den}) begin
                        n_rem = SEG_W'(v_rem2 - {1'b0, i_den});
                        n_quo = {n_quo[QW-2:0], 1'b1};
                    end else begin
                        n_rem = v_rem2[SEG_W-1:0];
                        n_quo = {n_quo[QW-2:0], 1'b0};
                    end
                    if (s * DIV_STEPS + b + 1 == TEX_FRAC) begin
                        n_rt = (n_rem >= w_half);
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_rt[s]  <= n_rt;
            end
        end
    end

    assign o_quo     = r_quo[DIV_STAGES-1];
    assign o_rnd_tex = r_rt[DIV_STAGES-1];
    assign o_rnd_fin = (r_rem[DIV_STAGES-1] >= w_half);

endmodule

>>> rtl/uvs_sinq.sv
// Quarter-wave sine in Q30: scale by pi/2, then a degree-9 Horner series.
// Depends on uvs_pkg.
`timescale 1ns / 1ps

module uvs_sinq
    import uvs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_f,
    output logic [30:0] o_s
);

    logic [61:0] r_pf;
    logic [30:0] r_x1;
    logic [61:0] r_px2;
    t_sin_carry  r_c2;
    logic [61:0] r_sp;
    logic [30:0] r_s;

    logic [63:0] r_p  [HORNER_N];
    logic [31:0] r_n  [HORNER_N];
    logic [63:0] r_pm [HORNER_N];
    logic [30:0] r_t  [HORNER_N];
    t_sin_carry  r_ca [HORNER_N];
    t_sin_carry  r_cb [HORNER_N];
    t_sin_carry  r_cc [HORNER_N];

    logic [30:0] w_x;
    logic [31:0] w_s;

    assign w_x = 31'((64'(r_pf) + RND30) >> 30);

    // Scale the fraction to radians, then square it
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pf    <= 62'(i_f) * 62'(PIH_Q30);
            r_x1    <= w_x;
            r_px2   <= 62'(w_x) * 62'(w_x);
            r_c2.x  <= r_x1;
            r_c2.x2 <= 32'((64'(r_px2) + RND30) >> 30);
        end
    end

    for (genvar h = 0; h < HORNER_N; h++) begin : g_horner
        logic [30:0] w_t_in;
        t_sin_carry  w_c_in;
        logic [31:0] w_n;
        logic [29:0] w_q0;
        logic [32:0] w_rr;
        logic [29:0] w_q;

        if (h == 0) begin : g_first
            assign w_t_in = ONE30;
            assign w_c_in = r_c2;
        end else begin : g_next
            assign w_t_in = r_t[h-1];
            assign w_c_in = r_cc[h-1];
        end

        // Rounded product plus offset, then reciprocal multiply
        assign w_n  = 32'((r_p[h] + RND30) >> 30) + 32'(horner_c(h));
        // Fix the reciprocal estimate with one compare
        assign w_q0 = r_pm[h][62:33];
        assign w_rr = {1'b0, r_n[h]} - 33'(w_q0) * 33'(horner_k(h));
        assign w_q  = w_q0 + 30'(w_rr >= 33'(horner_k(h)));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[h]  <= 64'(w_c_in.x2) * 64'(w_t_in);
                r_ca[h] <= w_c_in;
                r_n[h]  <= w_n;
                r_pm[h] <= 64'(w_n) * 64'(horner_m(h));
                r_cb[h] <= r_ca[h];
                r_t[h]  <= ONE30 - 31'(w_q);
                r_cc[h] <= r_cb[h];
            end
        end
    end

    // Final product x*t, round and clamp at one
    assign w_s = 32'((64'(r_sp) + RND30) >> 30);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sp <= 62'(r_cc[HORNER_N-1].x) * 62'(r_t[HORNER_N-1]);
            r_s  <= (w_s > 32'(ONE30)) ? ONE30 : w_s[30:0];
        end
    end

    assign o_s = r_s;

endmodule

>>> rtl/uv_sphere_tessellator.sv
// UV-sphere vertex generator: one grid point (row j, column i) in, one vertex out with
// Q1.15 position, Q1.16 texture coordinates and the quad's six triangle indices. Accepts one
// point per cycle while the output is not stalled; each vertex passes 29 register stages:
// the input register, the eight-stage restoring angle divider (32 steps for longitude, 31
// for latitude, four steps per stage), angle register, 17-stage sine series, product and
// output registers. The whole pipeline holds while a finished vertex waits on i_stall.
// Segment counts: configuration port, always ready; user writes only while idle (not enforced).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uv_sphere_tessellator
    import uvs_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_in,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SEG_REG_W-1:0] i_cfg_data
);

    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
    localparam int CMP_W = (SEG_W > STEP_W) ? SEG_W : STEP_W;
    localparam int MUL_W = (2 * SEG_W + 2 > IDX_W) ? 2 * SEG_W + 2 : IDX_W;
    localparam int VLD_N = 1 + DIV_STAGES + 1 + SIN_LAT + 1;

    logic [SEG_REG_W-1:0] r_lon_reg;
    logic [SEG_REG_W-1:0] r_lat_reg;
    logic [SEG_W-1:0]     w_lon;
    logic [SEG_W-1:0]     w_lat;

    logic                 w_en;
    logic                 r_vld [VLD_N];
    logic                 r_out_valid;
    t_out_item            r_out;

    logic [SEG_W-1:0]     w_j_c;
    logic [SEG_W-1:0]     w_i_c;
    logic [MUL_W-1:0]     w_first_full;
    logic [SEG_W-1:0]     r_j;
    logic [SEG_W-1:0]     r_i;
    t_idx                 r_idx;
    t_idx                 w_idx_d;

    logic [THETA_FRAC:0]  w_quo_t;
    logic [PHI_FRAC:0]    w_quo_p;
    logic                 w_rt_t;
    logic                 w_rf_t;
    logic                 w_rt_p;
    logic                 w_rf_p;
    logic [THETA_FRAC:0]  w_at;
    logic [PHI_FRAC:0]    w_ap;

    logic [29:0]          r_ft;
    logic [29:0]          r_fp;
    t_side                r_side;
    t_side                w_side_d;

    logic [30:0]          w_st_s;
    logic [30:0]          w_st_c;
    logic [30:0]          w_sp_s;
    logic [30:0]          w_sp_c;
    t_sc                  w_th;
    t_sc                  w_ph;
    t_c1                  r_c1;

    logic [IDX_W-1:0]     w_first;
    logic [IDX_W-1:0]     w_second;
    t_out_item            n_out;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lon_reg <= LON_RESET;
            r_lat_reg <= LAT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LON: r_lon_reg <= i_cfg_data;
                CFG_LAT: r_lat_reg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective segment counts: zero acts as one, clamp at the maximum
    assign w_lon = (r_lon_reg == '0) ? SEG_W'(1) :
                   (CMP_W'(r_lon_reg) > CMP_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) :
                   SEG_W'(r_lon_reg);
    assign w_lat = (r_lat_reg == '0) ? SEG_W'(1) :
                   (CMP_W'(r_lat_reg) > CMP_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) :
                   SEG_W'(r_lat_reg);

    // Whole-pipeline advance: hold only while a result waits on a stall
    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VLD_N; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < VLD_N; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_out_valid <= r_vld[VLD_N-1];
        end
    end

    // Input stage: clamp the steps and form the first quad index
    assign w_j_c = (CMP_W'(i_in.lat_step) > CMP_W'(w_lat)) ? w_lat : SEG_W'(i_in.lat_step);
    assign w_i_c = (CMP_W'(i_in.lon_step) > CMP_W'(w_lon)) ? w_lon : SEG_W'(i_in.lon_step);
    assign w_first_full = MUL_W'(w_j_c) * (MUL_W'(w_lon) + MUL_W'(1)) + MUL_W'(w_i_c);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_j            <= w_j_c;
            r_i            <= w_i_c;
            r_idx.has_quad <= (w_i_c < w_lon) && (w_j_c < w_lat);
            r_idx.first    <= w_first_full[IDX_W-1:0];
        end
    end

    // Angle and texture dividers
    uvs_div #(.SEG_W(SEG_W), .FRAC_BITS(THETA_FRAC)) u_div_theta (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_num     (r_j),
        .i_den     (w_lat),
        .o_quo     (w_quo_t),
        .o_rnd_tex (w_rt_t),
        .o_rnd_fin (w_rf_t)
    );

    uvs_div #(.SEG_W(SEG_W), .FRAC_BITS(PHI_FRAC)) u_div_phi (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_num     (r_i),
        .i_den     (w_lon),
        .o_quo     (w_quo_p),
        .o_rnd_tex (w_rt_p),
        .o_rnd_fin (w_rf_p)
    );

    uvs_dly #(.W($bits(t_idx)), .DEPTH(DIV_STAGES)) u_dly_idx (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_idx),
        .o_q   (w_idx_d)
    );

    // Round the angles, split quadrant and fraction, round the texture coordinates
    assign w_at = w_quo_t + (THETA_FRAC + 1)'(w_rf_t);
    assign w_ap = w_quo_p + (PHI_FRAC + 1)'(w_rf_p);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ft         <= w_at[29:0];
            r_fp         <= w_ap[29:0];
            r_side.qt    <= t_quad'(w_at[31:30]);
            r_side.qp    <= t_quad'(w_ap[31:30]);
            r_side.tex_u <= w_quo_p[PHI_FRAC -: TEX_W] + TEX_W'(w_rt_p);
            r_side.tex_v <= w_quo_t[THETA_FRAC -: TEX_W] + TEX_W'(w_rt_t);
            r_side.idx   <= w_idx_d;
        end
    end

    // Quarter-wave sine of the fraction and of its complement, both angles
    uvs_sinq u_sin_ts (.i_clk(i_clk), .i_en(w_en), .i_f({1'b0, r_ft}), .o_s(w_st_s));
    uvs_sinq u_sin_tc (.i_clk(i_clk), .i_en(w_en), .i_f(ONE30 - {1'b0, r_ft}), .o_s(w_st_c));
    uvs_sinq u_sin_ps (.i_clk(i_clk), .i_en(w_en), .i_f({1'b0, r_fp}), .o_s(w_sp_s));
    uvs_sinq u_sin_pc (.i_clk(i_clk), .i_en(w_en), .i_f(ONE30 - {1'b0, r_fp}), .o_s(w_sp_c));

    uvs_dly #(.W($bits(t_side)), .DEPTH(SIN_LAT)) u_dly_side (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_side),
        .o_q   (w_side_d)
    );

    // Fold by quadrant and form the position products
    assign w_th = sc_fold(w_side_d.qt, w_st_s, w_st_c);
    assign w_ph = sc_fold(w_side_d.qp, w_sp_s, w_sp_c);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1.mx    <= 62'(w_ph.cs_mag) * 62'(w_th.sn_mag);
            r_c1.x_neg <= w_ph.cs_neg ^ w_th.sn_neg;
            r_c1.mz    <= 62'(w_ph.sn_mag) * 62'(w_th.sn_mag);
            r_c1.z_neg <= w_ph.sn_neg ^ w_th.sn_neg;
            r_c1.ymag  <= 16'((32'(w_th.cs_mag) + 32'h0000_4000) >> 15);
            r_c1.y_neg <= w_th.cs_neg;
            r_c1.side  <= w_side_d;
        end
    end

    // Output register: scale to Q1.15 and build the triangle indices
    assign w_first  = r_c1.side.idx.first;
    assign w_second = w_first + IDX_W'(w_lon) + IDX_W'(1);

    always_comb begin
        n_out.pos_x = pack_q15(r_c1.x_neg,
                               16'((64'(r_c1.mx) + 64'h0000_1000_0000_0000) >> 45));
        n_out.pos_y = pack_q15(r_c1.y_neg, r_c1.ymag);
        n_out.pos_z = pack_q15(r_c1.z_neg,
                               16'((64'(r_c1.mz) + 64'h0000_1000_0000_0000) >> 45));
        n_out.tex_u    = r_c1.side.tex_u;
        n_out.tex_v    = r_c1.side.tex_v;
        n_out.has_quad = r_c1.side.idx.has_quad;
        if (r_c1.side.idx.has_quad) begin
            n_out.tri0_a = w_first;
            n_out.tri0_b = w_second;
            n_out.tri0_c = w_first + IDX_W'(1);
            n_out.tri1_a = w_second;
            n_out.tri1_b = w_second + IDX_W'(1);
            n_out.tri1_c = w_first + IDX_W'(1);
        end else begin
            n_out.tri0_a = '0;
            n_out.tri0_b = '0;
            n_out.tri0_c = '0;
            n_out.tri1_a = '0;
            n_out.tri1_b = '0;
            n_out.tri1_c = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // Checks
    `UVS_CHECK(a_stall_only_full, !o_stall || o_valid, "input stalled with no result waiting")
    `UVS_CHECK_NEXT(a_drain, o_valid && !i_stall && !r_vld[VLD_N-1], !o_valid,
                    "output valid without an item behind it")
    `UVS_CHECK(a_no_quad_zero, !(o_valid && !o_out.has_quad) ||
               (o_out.tri0_a == '0 && o_out.tri1_b == '0 && o_out.tri1_c == '0),
               "index fields set without a quad")
    `UVS_CHECK(a_quad_shape, !(o_valid && o_out.has_quad) ||
               (o_out.tri0_c == o_out.tri1_c && o_out.tri1_a == o_out.tri0_b),
               "triangle indices do not share the quad corners")

endmodule
